FILE: rtl/core/htfr_pkg.sv
// Shared constants and helper functions for the hex-text CRC-32 frame receiver.
package htfr_pkg;

    // Frame geometry
    localparam logic [3:0]  MAX_AREA_LEN = 4'd15;
    localparam int          STORE_DEPTH  = 14;
    localparam int          STORE_AW     = $clog2(STORE_DEPTH);
    localparam logic [3:0]  CRC_CHARS    = 4'd8;

    // Register reset and CRC constants
    localparam logic [15:0] HEADER_RESET = 16'hFFBE;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

    // Result fields moved into the output register
    typedef struct packed {
        logic [7:0] frame_id;
        logic [7:0] payload_byte;
        logic       payload_present;
        logic       last;
    } htfr_result_t;

    // Reflected CRC-32 update over one byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Any-case ASCII hex digit, zero for anything else
    function automatic logic [3:0] hex_digit_any(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    // Lowercase ASCII character for one nibble
    function automatic logic [7:0] lower_hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'h0, nib};
        end else begin
            ch = 8'h57 + {4'h0, nib};
        end
        return ch;
    endfunction

endpackage

FILE: rtl/core/hex_text_frame_receiver_crc32_unit.sv
// Top level of the hex-text frame receiver with CRC-32 check.
//
// Takes one received byte per item and hunts for the two header bytes in header_reg, reads
// one hex length digit (0..15, invalid digit = 0), then the data area (id byte and payload,
// payload kept in a 14-entry RAM) while a standard CRC-32 runs over it, then 8 lowercase hex
// CRC characters. A matching, non-empty frame gives one result per payload byte (one result
// with payload_present low for an id-only frame), last set on the final one; anything else is
// dropped. While parsing, one byte is accepted every cycle. After the last CRC character of a
// good frame, in_ready stays low during emission: each result takes a RAM read step, then an
// output register load step that waits while out_valid is high and out_ready is low. The
// payload RAM needs no clearing after reset.
module hex_text_frame_receiver_crc32_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_id,
    output logic [7:0]  payload_byte,
    output logic        payload_present,
    output logic        last
);

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CRC   = 3'd4;
    localparam logic [2:0] PH_EMRD  = 3'd5;
    localparam logic [2:0] PH_EMWR  = 3'd6;

    logic [15:0] header_reg;
    logic [2:0]  phase_reg,    phase_next;
    logic [3:0]  len_reg,      len_next;
    logic [3:0]  cnt_reg,      cnt_next;
    logic [31:0] crc_reg,      crc_next;
    logic [7:0]  id_reg,       id_next;
    logic        mism_reg,     mism_next;
    logic        out_valid_reg, out_valid_next;
    htfr_pkg::htfr_result_t res_reg, res_next;

    logic        accept;
    logic        out_load;
    logic [3:0]  num_pay;
    logic [4:0]  cnt_inc;
    logic [31:0] crc_fin;
    logic [2:0]  nib_sel;
    logic [3:0]  crc_nib;
    logic        mism_now;

    logic                          ram_we;
    logic [htfr_pkg::STORE_AW-1:0] ram_waddr;
    logic                          ram_re;
    logic [7:0]                    ram_rdata;

    // Payload store; writes happen only in the data phase and reads only during emission,
    // so the phase sequence keeps the two apart
    htfr_ram #(
        .WIDTH (8),
        .DEPTH (htfr_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (cnt_reg[htfr_pkg::STORE_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign in_ready = (phase_reg != PH_EMRD) && (phase_reg != PH_EMWR);
    assign accept   = in_valid && in_ready;
    assign num_pay  = len_reg - 4'd1;
    assign cnt_inc  = {1'b0, cnt_reg} + 5'd1;
    assign out_load = (phase_reg == PH_EMWR) && (!out_valid_reg || out_ready);

    // Expected CRC character, most significant nibble first
    assign crc_fin  = ~crc_reg;
    assign nib_sel  = 3'd7 - cnt_reg[2:0];
    assign crc_nib  = crc_fin[{nib_sel, 2'b00} +: 4];
    assign mism_now = mism_reg || (rx_byte != htfr_pkg::lower_hex_char(crc_nib));

    // Store write for payload bytes (counter 1 onwards)
    assign ram_we    = accept && (phase_reg == PH_DATA) && (cnt_reg != 4'd0)
                       && ({1'b0, cnt_reg} <= 5'(htfr_pkg::STORE_DEPTH));
    assign ram_waddr = htfr_pkg::STORE_AW'(cnt_reg - 4'd1);
    assign ram_re    = (phase_reg == PH_EMRD) && (num_pay != 4'd0);

    // Parser and emission sequencer
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        id_next    = id_reg;
        mism_next  = mism_reg;
        res_next   = res_reg;
        unique case (phase_reg)
            PH_HUNT2:
            begin
                if (accept)
                begin
                    if (rx_byte == header_reg[7:0])
                        phase_next = PH_LEN;
                    else if (rx_byte == header_reg[15:8])
                        phase_next = PH_HUNT2;
                    else
                        phase_next = PH_HUNT1;
                end
            end
            PH_LEN:
            begin
                if (accept)
                begin
                    len_next = htfr_pkg::hex_digit_any(rx_byte);
                    if (len_next > htfr_pkg::MAX_AREA_LEN)
                        len_next = htfr_pkg::MAX_AREA_LEN;
                    cnt_next   = 4'd0;
                    crc_next   = htfr_pkg::CRC_INIT;
                    mism_next  = 1'b0;
                    phase_next = (len_next == 4'd0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (accept)
                begin
                    crc_next = htfr_pkg::crc_byte(crc_reg, rx_byte);
                    if (cnt_reg == 4'd0)
                        id_next = rx_byte;
                    if (cnt_inc >= {1'b0, len_reg})
                    begin
                        cnt_next   = 4'd0;
                        phase_next = PH_CRC;
                    end
                    else
                    begin
                        cnt_next = cnt_inc[3:0];
                    end
                end
            end
            PH_CRC:
            begin
                if (accept)
                begin
                    if (cnt_inc >= {1'b0, htfr_pkg::CRC_CHARS})
                    begin
                        cnt_next   = 4'd0;
                        mism_next  = 1'b0;
                        phase_next = (!mism_now && len_reg != 4'd0) ? PH_EMRD : PH_HUNT1;
                    end
                    else
                    begin
                        cnt_next  = cnt_inc[3:0];
                        mism_next = mism_now;
                    end
                end
            end
            PH_EMRD:
            begin
                phase_next = PH_EMWR;
            end
            PH_EMWR:
            begin
                if (out_load)
                begin
                    res_next.frame_id        = id_reg;
                    res_next.payload_byte    = (num_pay == 4'd0) ? 8'h00 : ram_rdata;
                    res_next.payload_present = (num_pay != 4'd0);
                    res_next.last            = (num_pay == 4'd0) || (cnt_inc[3:0] == num_pay);
                    if (res_next.last)
                    begin
                        cnt_next   = 4'd0;
                        phase_next = PH_HUNT1;
                    end
                    else
                    begin
                        cnt_next   = cnt_inc[3:0];
                        phase_next = PH_EMRD;
                    end
                end
            end
            default:
            begin
                // hunting for the first header byte; spare codes land here too
                if (accept)
                    phase_next = (rx_byte == header_reg[15:8]) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= htfr_pkg::HEADER_RESET;
            phase_reg     <= PH_HUNT1;
            len_reg       <= 4'd0;
            cnt_reg       <= 4'd0;
            crc_reg       <= htfr_pkg::CRC_INIT;
            id_reg        <= 8'h00;
            mism_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                header_reg <= cfg_wdata;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            crc_reg       <= crc_next;
            id_reg        <= id_next;
            mism_reg      <= mism_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid       = out_valid_reg;
    assign frame_id        = res_reg.frame_id;
    assign payload_byte    = res_reg.payload_byte;
    assign payload_present = res_reg.payload_present;
    assign last            = res_reg.last;

    // Emission is only entered from the CRC phase
    a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EMRD && $past(phase_reg) != PH_EMWR) |-> $past(phase_reg) == PH_CRC)
        else $error("emission entered from an unexpected phase");

    // Read index stays inside the store while emitting
    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EMRD || phase_reg == PH_EMWR)
            |-> {1'b0, cnt_reg} < 5'(htfr_pkg::STORE_DEPTH))
        else $error("payload read index out of range");

    // Store is written only by an accepted data byte
    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (phase_reg == PH_DATA && accept))
        else $error("payload store written outside the data phase");

    // Loading the final result of a frame returns the parser to hunting
    a_last_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_next.last) |=> (phase_reg == PH_HUNT1 && out_valid_reg))
        else $error("parser not back to hunting after final result");

endmodule

FILE: rtl/core/htfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module htfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: verif/htfr_checker.sv
// Scoreboard for the hex-text frame receiver: follows the byte stream, predicts and compares.
module htfr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  frame_id,
    input  logic [7:0]  payload_byte,
    input  logic        payload_present,
    input  logic        last,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] SEEK_FIRST  = 3'd0;
    localparam logic [2:0] SEEK_SECOND = 3'd1;
    localparam logic [2:0] READ_LEN    = 3'd2;
    localparam logic [2:0] READ_AREA   = 3'd3;
    localparam logic [2:0] READ_CRC    = 3'd4;

    // Shadow copy of the receiver state
    logic [15:0]  hdr;
    logic [2:0]   phase;
    logic [3:0]   area_len;
    logic [3:0]   count;
    logic [31:0]  crc_acc;
    logic [7:0]   id_byte;
    logic [7:0]   payload_copy [htfr_pkg::STORE_DEPTH];
    logic         bad_crc;
    int           errors;

    // Results still owed by the block, oldest first
    htfr_pkg::htfr_result_t owed_results[$];

    // One byte through the reflected CRC-32, LSB first
    function automatic logic [31:0] crc32_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] acc;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            if (acc[0] ^ b[i]) begin
                acc = (acc >> 1) ^ htfr_pkg::CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    // Length digit in either case; anything else reads as zero
    function automatic logic [3:0] length_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return 4'(c - "0");
        end
        if (c >= "a" && c <= "f") begin
            return 4'(c - "a" + 10);
        end
        if (c >= "A" && c <= "F") begin
            return 4'(c - "A" + 10);
        end
        return 4'd0;
    endfunction

    function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'("0" + nib) : 8'("a" + nib - 10);
    endfunction

    // Advance the shadow parser by one accepted byte and queue what it owes
    task automatic absorb_byte(input logic [7:0] b);
        logic [31:0]  fin;
        logic [3:0]   nib;
        htfr_pkg::htfr_result_t r;
        unique case (phase)
            SEEK_SECOND:
            begin
                if (b == hdr[7:0]) begin
                    phase = READ_LEN;
                end else if (b == hdr[15:8]) begin
                    phase = SEEK_SECOND;
                end else begin
                    phase = SEEK_FIRST;
                end
            end
            READ_LEN:
            begin
                area_len = length_value(b);
                if (area_len > htfr_pkg::MAX_AREA_LEN) begin
                    area_len = htfr_pkg::MAX_AREA_LEN;
                end
                count   = 4'd0;
                crc_acc = htfr_pkg::CRC_INIT;
                bad_crc = 1'b0;
                phase   = (area_len == 4'd0) ? READ_CRC : READ_AREA;
            end
            READ_AREA:
            begin
                crc_acc = crc32_feed(crc_acc, b);
                if (count == 4'd0) begin
                    id_byte = b;
                end else if (int'(count) - 1 < htfr_pkg::STORE_DEPTH) begin
                    payload_copy[int'(count) - 1] = b;
                end
                count = count + 4'd1;
                if (count >= area_len) begin
                    count = 4'd0;
                    phase = READ_CRC;
                end
            end
            READ_CRC:
            begin
                // CRC text arrives most significant nibble first
                fin = ~crc_acc;
                nib = 4'(fin >> (28 - 4 * int'(count[2:0])));
                if (b != ascii_nibble(nib)) begin
                    bad_crc = 1'b1;
                end
                count = count + 4'd1;
                if (count >= htfr_pkg::CRC_CHARS) begin
                    if (!bad_crc && area_len != 4'd0) begin
                        if (area_len == 4'd1) begin
                            r = {id_byte, 8'h00, 1'b0, 1'b1};
                            owed_results.push_back(r);
                        end else begin
                            for (int k = 0; k < int'(area_len) - 1 && k < htfr_pkg::STORE_DEPTH;
                                 k++) begin
                                r = {id_byte, payload_copy[k], 1'b1,
                                     1'(k == int'(area_len) - 2)};
                                owed_results.push_back(r);
                            end
                        end
                    end
                    count   = 4'd0;
                    bad_crc = 1'b0;
                    phase   = SEEK_FIRST;
                end
            end
            default:
            begin
                phase = (b == hdr[15:8]) ? SEEK_SECOND : SEEK_FIRST;
            end
        endcase
    endtask

    // Watch both channels and the register port at every edge
    always @(posedge clk or negedge rst_n)
    begin
        htfr_pkg::htfr_result_t seen;
        htfr_pkg::htfr_result_t want;
        if (!rst_n) begin
            hdr      = htfr_pkg::HEADER_RESET;
            phase    = SEEK_FIRST;
            area_len = 4'd0;
            count    = 4'd0;
            crc_acc  = htfr_pkg::CRC_INIT;
            id_byte  = 8'h00;
            bad_crc  = 1'b0;
            owed_results.delete();
            pending_count <= 0;
        end else begin
            // results leave a register, so none can stem from this edge's input item
            if (out_valid && out_ready) begin
                seen = {frame_id, payload_byte, payload_present, last};
                if (owed_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result id=%h byte=%h present=%b last=%b",
                             $realtime, frame_id, payload_byte, payload_present, last);
                end else begin
                    want = owed_results.pop_front();
                    if (seen !== want) begin
                        errors++;
                        // fields in order id/byte/present/last
                        $display("%0t: result expected %h/%h/%b/%b, got %h/%h/%b/%b",
                                 $realtime, want.frame_id, want.payload_byte,
                                 want.payload_present, want.last, frame_id, payload_byte,
                                 payload_present, last);
                    end
                end
            end
            // an item at this edge still sees the old header
            if (in_valid && in_ready) begin
                absorb_byte(rx_byte);
            end
            if (cfg_we) begin
                hdr = cfg_wdata;
            end
            pending_count <= owed_results.size();
        end
        fail_count <= errors;
    end

endmodule

FILE: verif/tb_hex_text_frame_receiver_crc32_unit.sv
// Stimulus and verdict for the hex-text CRC-32 frame receiver, checked by htfr_checker.
module tb_hex_text_frame_receiver_crc32_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_BYTES  = 20;
    localparam int FILL_RANDOM  = 0;
    localparam int FILL_ZEROS   = 1;
    localparam int FILL_EDGES   = 2;

    typedef enum int {
        CRC_GOOD,
        CRC_UPPER,
        CRC_FLIP,
        CRC_JUNK
    } crc_fault_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  frame_id;
    logic [7:0]  payload_byte;
    logic        payload_present;
    logic        last;
    int          fail_count;
    int          pending_count;

    logic [15:0] hdr_now = htfr_pkg::HEADER_RESET;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          stall_tick = 0;

    hex_text_frame_receiver_crc32_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_id        (frame_id),
        .payload_byte    (payload_byte),
        .payload_present (payload_present),
        .last            (last)
    );

    htfr_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_id        (frame_id),
        .payload_byte    (payload_byte),
        .payload_present (payload_present),
        .last            (last),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver stalls: the mode changes in turn, from always ready to long stalls
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        unique case ((stall_tick / 200) % 4)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= (stall_tick % 7 == 0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // CRC-32 used to build well-formed frames
    function automatic logic [31:0] frame_crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        repeat (8) begin
            c = c[0] ? ((c >> 1) ^ htfr_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_lower(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'("0" + nib) : 8'("a" + nib - 10);
    endfunction

    // Length digit for 0..15, letters in either case
    function automatic logic [7:0] length_char(input int len);
        if (len < 10) begin
            return 8'("0" + len);
        end
        return ($urandom_range(0, 1) == 1) ? 8'("a" + len - 10) : 8'("A" + len - 10);
    endfunction

    // One byte over the input channel, in bursts with random gaps
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Hold the input until every owed result is out, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_header(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        hdr_now = value;
    endtask

    // Header, length digit, data area and CRC text, with an optional CRC fault
    task automatic send_frame(input int len, input logic [7:0] len_ch,
                              input crc_fault_t fault, input int fill);
        logic [7:0]  area[$];
        logic [31:0] crc;
        logic [7:0]  ch;
        logic [3:0]  nib;
        int          pick;
        area = {};
        for (int k = 0; k < len; k++) begin
            unique case (fill)
                FILL_ZEROS: area.push_back(8'h00);
                FILL_EDGES: area.push_back((k % 2 == 0) ? 8'hFF : 8'h00);
                default:    area.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        crc = htfr_pkg::CRC_INIT;
        foreach (area[k]) begin
            crc = frame_crc_step(crc, area[k]);
        end
        crc = ~crc;
        send_byte(hdr_now[15:8]);
        send_byte(hdr_now[7:0]);
        send_byte(len_ch);
        foreach (area[k]) begin
            send_byte(area[k]);
        end
        pick = $urandom_range(0, 7);
        for (int k = 0; k < 8; k++) begin
            nib = 4'(crc >> (28 - 4 * k));
            ch  = hex_lower(nib);
            unique case (fault)
                CRC_UPPER:
                begin
                    if (ch >= "a") begin
                        ch = ch - 8'h20;
                    end
                end
                CRC_FLIP:
                begin
                    if (k == pick) begin
                        ch = hex_lower(nib ^ 4'($urandom_range(1, 15)));
                    end
                end
                CRC_JUNK:
                begin
                    if (k == pick) begin
                        ch = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h67, 8'hFF))
                                                         : 8'($urandom_range(8'h00, 8'h2F));
                    end
                end
                default:
                begin
                end
            endcase
            send_byte(ch);
        end
    endtask

    // Mostly good frames of random content, with faulty frames, broken headers and line noise
    task automatic run_random_phase();
        int         start;
        int         good;
        int         pick;
        int         len;
        logic [7:0] b;
        start = bytes_sent;
        good  = 0;
        while (bytes_sent - start < PHASE_BYTES || good == 0) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15);
            if (pick < 60) begin
                send_frame(len, length_char(len), CRC_GOOD, FILL_RANDOM);
                if (len > 0) begin
                    good++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    drain();
                end
            end else if (pick < 72) begin
                send_frame(len, length_char(len), crc_fault_t'($urandom_range(1, 3)),
                           FILL_RANDOM);
            end else if (pick < 78) begin
                // repeated first header byte
                send_byte(hdr_now[15:8]);
                send_frame(len, length_char(len), CRC_GOOD, FILL_RANDOM);
                good++;
            end else if (pick < 84) begin
                // first header byte followed by a stray byte
                do b = 8'($urandom_range(0, 255));
                while (b == hdr_now[7:0] || b == hdr_now[15:8]);
                send_byte(hdr_now[15:8]);
                send_byte(b);
                send_frame(len, length_char(len), CRC_GOOD, FILL_RANDOM);
                good++;
            end else if (pick < 90) begin
                send_frame(0, 8'($urandom_range(8'h67, 8'hFF)), CRC_GOOD, FILL_RANDOM);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        logic [15:0] headers [3];
        headers = '{16'h0000, 16'hFFFF, 16'($urandom_range(0, 65535))};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset header
        send_frame(1, "1", CRC_GOOD, FILL_ZEROS);
        send_frame(15, "f", CRC_GOOD, FILL_EDGES);
        send_frame(0, "g", CRC_GOOD, FILL_RANDOM);
        send_frame(4, "4", CRC_UPPER, FILL_RANDOM);
        send_frame(3, "3", CRC_FLIP, FILL_RANDOM);
        send_byte(hdr_now[15:8]);
        send_frame(2, "2", CRC_GOOD, FILL_RANDOM);
        drain();

        // Random traffic under several header settings, extremes included
        foreach (headers[i]) begin
            write_header(headers[i]);
            run_random_phase();
            drain();
        end

        if (fail_count == 0) begin
            $display("tb_hex_text_frame_receiver_crc32_unit: PASS");
        end else begin
            $display("tb_hex_text_frame_receiver_crc32_unit: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("tb_hex_text_frame_receiver_crc32_unit: FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/htfr_pkg.sv
rtl/core/htfr_ram.sv
rtl/core/hex_text_frame_receiver_crc32_unit.sv
verif/htfr_checker.sv
verif/tb_hex_text_frame_receiver_crc32_unit.sv
